// ===== sv/flmrh_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_pkg
// Shared widths, per-lane mixing constants and lane control types for the
// four-lane multiply-rotate hash.
// ----------------------------------------------------------------------------
package flmrh_pkg;

  localparam int NUM_LANES = 4;
  localparam int WORD_W    = 64;
  localparam int HALF_W    = 32;
  localparam int LEN_W     = 32;

  localparam logic [WORD_W-1:0] MIX_A [NUM_LANES] = '{
    64'h39BDE3EE19A8BA27, 64'hBA1B0AC3AB867D38,
    64'h6D3BCCC3981F33CE, 64'hC3FBA33BD33BA621
  };
  localparam logic [WORD_W-1:0] MIX_B [NUM_LANES] = '{
    64'hC9A1BA38A0B3FEDD, 64'h9C210AE3ABB91073,
    64'h0B9AEE71139AB058, 64'h3FCAB09A08308BA1
  };
  localparam logic [WORD_W-1:0] FIN_A [2] = '{
    64'h2AC4FBE92A76C577, 64'h6C3E39A1657919A3
  };
  localparam logic [WORD_W-1:0] FIN_B [2] = '{
    64'hB9A7C56EFD4FBCAB, 64'hDA376BA7CDEA8C7B
  };
  localparam logic [WORD_W-1:0] HASH_ADD  = 64'hB3A1A55DEF917A7C;
  localparam logic [WORD_W-1:0] SEED_RST  = 64'h0;

  typedef struct packed {
    logic start;
    logic finish;
    logic load_seed;
  } lane_ctrl_t;

  typedef struct packed {
    logic              busy;
    logic [WORD_W-1:0] fin_hash;
  } lane_stat_t;

endpackage

// ===== sv/flmrh_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_in_if
// Block input channel: four 64-bit words, last flag and message length.
// ----------------------------------------------------------------------------
interface flmrh_in_if;
  logic                         valid;
  logic                         ready;
  logic [flmrh_pkg::WORD_W-1:0] block_word0;
  logic [flmrh_pkg::WORD_W-1:0] block_word1;
  logic [flmrh_pkg::WORD_W-1:0] block_word2;
  logic [flmrh_pkg::WORD_W-1:0] block_word3;
  logic                         last_block;
  logic [flmrh_pkg::LEN_W-1:0]  message_length;

  modport source (
    output valid, block_word0, block_word1, block_word2, block_word3,
           last_block, message_length,
    input  ready
  );
  modport sink (
    input  valid, block_word0, block_word1, block_word2, block_word3,
           last_block, message_length,
    output ready
  );
endinterface

// ===== sv/flmrh_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_out_if
// Result channel: one signed 64-bit hash per message.
// ----------------------------------------------------------------------------
interface flmrh_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [flmrh_pkg::WORD_W-1:0] hash_value;

  modport source (
    output valid, hash_value,
    input  ready
  );
  modport sink (
    input  valid, hash_value,
    output ready
  );
endinterface

// ===== sv/four_lane_multiply_rotate_hash.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// four_lane_multiply_rotate_hash
// Four-lane 64-bit multiply-rotate block hash with a seed register.
//
// in_ch takes one 32-byte block per transaction as four 64-bit words plus a
// last flag and the message length. out_ch gives one signed 64-bit hash per
// message, after its last block. cfg_wr_en/cfg_wr_data write the seed, which
// reloads all four lane hashes at once; write it only while the block idles.
// Each lane mixes its word through two 64x64 multiplies, each done by a
// 32x32 partial-product multiplier; a last block adds two finalising
// multiplies in every lane before its hash goes to the output register.
// One block is in flight at a time. The result waits in an output register:
// a stalled receiver holds only a following last block, never earlier
// blocks of a message.
// Reset clears the seed and all lane hashes to zero and empties the output.
// ----------------------------------------------------------------------------
module four_lane_multiply_rotate_hash (
  input  logic                         clk,
  input  logic                         rst_n,
  flmrh_in_if.sink                     in_ch,
  flmrh_out_if.source                  out_ch,
  input  logic                         cfg_wr_en,
  input  logic [flmrh_pkg::WORD_W-1:0] cfg_wr_data
);
  import flmrh_pkg::*;

  typedef enum logic [1:0] {T_IDLE, T_RUN, T_OUT} top_state_t;

  top_state_t        state_r;
  logic              last_r;
  logic [WORD_W-1:0] seed_r, seed_nxt;
  logic              in_acc, any_busy, merge_load, merge_can_load;
  logic [WORD_W-1:0] words [NUM_LANES];
  lane_ctrl_t        lane_ctrl [NUM_LANES];
  lane_stat_t        lane_stat [NUM_LANES];

  assign in_ch.ready = (state_r == T_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign seed_nxt    = cfg_wr_en ? cfg_wr_data : seed_r;
  assign merge_load  = (state_r == T_OUT);

  assign words[0] = in_ch.block_word0;
  assign words[1] = in_ch.block_word1;
  assign words[2] = in_ch.block_word2;
  assign words[3] = in_ch.block_word3;

  always_comb begin
    any_busy = 1'b0;
    for (int i = 0; i < NUM_LANES; i++) begin
      any_busy = any_busy | lane_stat[i].busy;
    end
  end

  for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
    assign lane_ctrl[g].start     = in_acc;
    assign lane_ctrl[g].finish    = in_ch.last_block;
    assign lane_ctrl[g].load_seed = cfg_wr_en;

    flmrh_lane #(.LANE_IDX(g)) lane_i (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (lane_ctrl[g]),
      .word    (words[g]),
      .msg_len (in_ch.message_length),
      .seed    (seed_nxt),
      .stat    (lane_stat[g])
    );
  end

  flmrh_merge merge_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (merge_load),
    .lane0_hash (lane_stat[0].fin_hash),
    .lane1_hash (lane_stat[1].fin_hash),
    .can_load   (merge_can_load),
    .out_ch     (out_ch)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
      last_r  <= 1'b0;
      seed_r  <= SEED_RST;
    end else begin
      seed_r <= seed_nxt;
      unique case (state_r)
        T_IDLE: begin
          if (in_acc) begin
            last_r  <= in_ch.last_block;
            state_r <= T_RUN;
          end
        end
        T_RUN: begin
          if (!any_busy) begin
            state_r <= last_r ? T_OUT : T_IDLE;
          end
        end
        T_OUT: begin
          if (merge_can_load) begin
            state_r <= T_IDLE;
          end
        end
        default: state_r <= T_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/flmrh_mul64.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_mul64
// 64x64 multiplier, low 64 bits of the product, built from one 32x32
// multiplier over three partial products.
// ----------------------------------------------------------------------------
module flmrh_mul64 (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [flmrh_pkg::WORD_W-1:0] op_a,
  input  logic [flmrh_pkg::WORD_W-1:0] op_b,
  output logic                         done,
  output logic [flmrh_pkg::WORD_W-1:0] product
);
  import flmrh_pkg::*;

  logic [WORD_W-1:0] a_r, b_r;
  logic [WORD_W-1:0] pp_r, acc_r;
  logic [1:0]        cnt_r;
  logic              act_r, done_r;
  logic [HALF_W-1:0] sel_a, sel_b;
  logic [WORD_W-1:0] pp_nxt;

  always_comb begin
    unique case (cnt_r)
      2'd0: begin
        sel_a = a_r[HALF_W-1:0];
        sel_b = b_r[HALF_W-1:0];
      end
      2'd1: begin
        sel_a = a_r[HALF_W-1:0];
        sel_b = b_r[WORD_W-1:HALF_W];
      end
      2'd2, 2'd3: begin
        sel_a = a_r[WORD_W-1:HALF_W];
        sel_b = b_r[HALF_W-1:0];
      end
    endcase
    pp_nxt = WORD_W'(sel_a) * WORD_W'(sel_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      cnt_r  <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        act_r <= 1'b1;
        cnt_r <= 2'd0;
      end else if (act_r) begin
        cnt_r <= cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          act_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= op_a;
      b_r <= op_b;
    end else if (act_r) begin
      pp_r <= pp_nxt;
      unique case (cnt_r)
        2'd0: ;
        2'd1: acc_r <= pp_r;
        2'd2, 2'd3: acc_r[WORD_W-1:HALF_W] <= acc_r[WORD_W-1:HALF_W] + pp_r[HALF_W-1:0];
      endcase
    end
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== sv/flmrh_lane.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_lane
// One hash lane: mixes its block word into the running lane hash and, on
// request, finalises the lane with the message length.
// ----------------------------------------------------------------------------
module flmrh_lane #(
  parameter int LANE_IDX = 0
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  flmrh_pkg::lane_ctrl_t        ctrl,
  input  logic [flmrh_pkg::WORD_W-1:0] word,
  input  logic [flmrh_pkg::LEN_W-1:0]  msg_len,
  input  logic [flmrh_pkg::WORD_W-1:0] seed,
  output flmrh_pkg::lane_stat_t        stat
);
  import flmrh_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_MA_GO, S_MA_W, S_MB_GO, S_MB_W, S_FOLD, S_TIMES5, S_ADDC,
    S_FX, S_F1_GO, S_F1_W, S_F2_GO, S_F2_W
  } lane_state_t;

  lane_state_t       state_r;
  logic [WORD_W-1:0] hash_r, k_r;
  logic [LEN_W-1:0]  len_r;
  logic              fin_r;
  logic              mul_start, mul_done;
  logic [WORD_W-1:0] mul_b, mul_p;
  logic [WORD_W-1:0] fold_x, fin_x;

  always_comb begin
    mul_start = 1'b0;
    unique case (state_r)
      S_MA_GO: begin
        mul_start = 1'b1;
        mul_b     = MIX_A[LANE_IDX];
      end
      S_MB_GO: begin
        mul_start = 1'b1;
        mul_b     = MIX_B[LANE_IDX];
      end
      S_F1_GO: begin
        mul_start = 1'b1;
        mul_b     = FIN_A[LANE_IDX % 2];
      end
      S_F2_GO: begin
        mul_start = 1'b1;
        mul_b     = FIN_B[LANE_IDX % 2];
      end
      default: mul_b = MIX_A[LANE_IDX];
    endcase
    fold_x = hash_r ^ k_r;
    fin_x  = hash_r ^ WORD_W'(len_r);
  end

  flmrh_mul64 mul_i (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start),
    .op_a    (k_r),
    .op_b    (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hash_r  <= SEED_RST;
      fin_r   <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (ctrl.load_seed) begin
            hash_r <= seed;
          end
          if (ctrl.start) begin
            fin_r   <= ctrl.finish;
            state_r <= S_MA_GO;
          end
        end
        S_MA_GO:  state_r <= S_MA_W;
        S_MA_W:   if (mul_done) state_r <= S_MB_GO;
        S_MB_GO:  state_r <= S_MB_W;
        S_MB_W:   if (mul_done) state_r <= S_FOLD;
        S_FOLD: begin
          hash_r  <= {fold_x[WORD_W-14:0], fold_x[WORD_W-1:WORD_W-13]};
          state_r <= S_TIMES5;
        end
        S_TIMES5: begin
          hash_r  <= {hash_r[WORD_W-3:0], 2'b00} + hash_r;
          state_r <= S_ADDC;
        end
        S_ADDC: begin
          hash_r  <= hash_r + HASH_ADD;
          state_r <= fin_r ? S_FX : S_IDLE;
        end
        S_FX: begin
          hash_r  <= seed;
          state_r <= S_F1_GO;
        end
        S_F1_GO:  state_r <= S_F1_W;
        S_F1_W:   if (mul_done) state_r <= S_F2_GO;
        S_F2_GO:  state_r <= S_F2_W;
        S_F2_W:   if (mul_done) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && ctrl.start) begin
      k_r   <= word;
      len_r <= msg_len;
    end else if (state_r == S_MA_W && mul_done) begin
      k_r <= {mul_p[WORD_W-16:0], mul_p[WORD_W-1:WORD_W-15]};
    end else if (state_r == S_MB_W && mul_done) begin
      k_r <= mul_p;
    end else if (state_r == S_FX) begin
      k_r <= fin_x ^ (fin_x >> 16);
    end else if (state_r == S_F1_W && mul_done) begin
      k_r <= mul_p ^ (mul_p >> 13);
    end else if (state_r == S_F2_W && mul_done) begin
      k_r <= mul_p ^ (mul_p >> 16);
    end
  end

  assign stat.busy     = (state_r != S_IDLE);
  assign stat.fin_hash = k_r;

endmodule

// ===== sv/flmrh_merge.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_merge
// Folds the 32-bit words of the two finalised lanes into one 64-bit hash
// and holds it in the output register until the receiver takes it.
// ----------------------------------------------------------------------------
module flmrh_merge (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         load,
  input  logic [flmrh_pkg::WORD_W-1:0] lane0_hash,
  input  logic [flmrh_pkg::WORD_W-1:0] lane1_hash,
  output logic                         can_load,
  flmrh_out_if.source                  out_ch
);
  import flmrh_pkg::*;

  logic              valid_r;
  logic [WORD_W-1:0] hash_r;
  logic [WORD_W-1:0] fold;
  logic [HALF_W-1:0] w0, w1, w2, w3;

  function automatic logic [WORD_W-1:0] sext(input logic [HALF_W-1:0] w);
    sext = {{HALF_W{w[HALF_W-1]}}, w};
  endfunction

  always_comb begin
    w0   = lane0_hash[HALF_W-1:0];
    w1   = lane0_hash[WORD_W-1:HALF_W];
    w2   = lane1_hash[HALF_W-1:0];
    w3   = lane1_hash[WORD_W-1:HALF_W];
    fold = {w1, {HALF_W{1'b0}}} ^ sext(w0);
    fold = (fold | {w2, {HALF_W{1'b0}}}) ^ sext(w1);
    fold = (fold | {w3, {HALF_W{1'b0}}}) ^ sext(w2);
    fold = fold ^ sext(w3);
  end

  assign can_load = !valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && can_load) begin
      valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      hash_r <= fold;
    end
  end

  assign out_ch.valid      = valid_r;
  assign out_ch.hash_value = signed'(hash_r);

endmodule

// ===== sv/flmrh_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flmrh_chk
// Port-level checks for the four-lane hash, bound to the top level.
// ----------------------------------------------------------------------------
module flmrh_chk (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [flmrh_pkg::WORD_W-1:0] hash_value
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(hash_value))
    else $error("stalled result changed");

  a_one_block: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("second transaction taken while a block is in flight");

  a_no_fast_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !$rose(out_valid))
    else $error("result appeared one cycle after a transaction");

  a_out_frees_in: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> in_ready && $past(!in_ready))
    else $error("result loaded without the block finishing a message");

endmodule

bind four_lane_multiply_rotate_hash flmrh_chk chk_i (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .hash_value (out_ch.hash_value)
);

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the four-lane multiply-rotate hash. A queue of
// 32-byte blocks feeds a clocked driver with random gaps. Each accepted
// transaction runs through a bit-exact lane model that keeps its own seed
// and lane hashes, and the hash of every finished message is queued. The
// monitor stalls at random and checks each hash against the oldest queued
// value. Seed writes happen only while the block idles: extreme and random
// seeds, plus a write that drops a message in progress. One phase holds the
// output off long enough to back the input up.
// ----------------------------------------------------------------------------
module tb_top;
  import flmrh_pkg::*;

  localparam int    CLK_HALF      = 10;
  localparam int    RESET_CYCLES  = 10;
  localparam int    RANDOM_ITEMS  = 600;
  localparam int    PHASE_ITEMS   = 90;
  localparam int    SETTLE_CYCLES = 80;
  localparam int    HOLD_CYCLES   = 400;
  localparam longint RUN_LIMIT_NS = 64'd20_000_000;

  localparam logic [63:0] LANE_MUL_A [4] = '{
    64'h39BDE3EE19A8BA27, 64'hBA1B0AC3AB867D38,
    64'h6D3BCCC3981F33CE, 64'hC3FBA33BD33BA621
  };
  localparam logic [63:0] LANE_MUL_B [4] = '{
    64'hC9A1BA38A0B3FEDD, 64'h9C210AE3ABB91073,
    64'h0B9AEE71139AB058, 64'h3FCAB09A08308BA1
  };
  localparam logic [63:0] FIN_MUL_A [2] = '{64'h2AC4FBE92A76C577, 64'h6C3E39A1657919A3};
  localparam logic [63:0] FIN_MUL_B [2] = '{64'hB9A7C56EFD4FBCAB, 64'hDA376BA7CDEA8C7B};
  localparam logic [63:0] LANE_ADD = 64'hB3A1A55DEF917A7C;

  typedef struct packed {
    logic [3:0][WORD_W-1:0] words;
    logic                   last;
    logic [LEN_W-1:0]       len;
  } block_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [WORD_W-1:0] cfg_wr_data;

  flmrh_in_if  in_ch ();
  flmrh_out_if out_ch ();

  four_lane_multiply_rotate_hash dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  logic [WORD_W-1:0]        seed_q;
  logic [WORD_W-1:0]        lane_q [4];
  logic signed [WORD_W-1:0] hash_expected_q [$];
  block_t                   pending_blocks [$];
  block_t                   cur_block;
  int                       gap_left;
  int                       stall_left;
  int                       hold_left;
  int                       err_cnt;
  bit                       calm_phase;
  bit                       hold_req;

  always #(CLK_HALF) clk = ~clk;

  function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned r);
    return (v << r) | (v >> (64 - r));
  endfunction

  function automatic logic [63:0] finish_lane(input logic [63:0] h, input logic [31:0] len,
                                              input int lane);
    logic [63:0] x;
    x = h ^ {32'h0, len};
    x = x ^ (x >> 16);
    x = x * FIN_MUL_A[lane];
    x = x ^ (x >> 13);
    x = x * FIN_MUL_B[lane];
    x = x ^ (x >> 16);
    return x;
  endfunction

  function automatic void reload_lanes();
    for (int i = 0; i < 4; i++) lane_q[i] = seed_q;
  endfunction

  function automatic void absorb_block(input block_t b);
    logic [63:0] k;
    logic [63:0] h0;
    logic [63:0] h1;
    logic [63:0] r;
    logic [31:0] wd [5];
    for (int i = 0; i < 4; i++) begin
      k = b.words[i] * LANE_MUL_A[i];
      k = rotl64(k, 15);
      k = k * LANE_MUL_B[i];
      lane_q[i] = rotl64(lane_q[i] ^ k, 13) * 64'd5 + LANE_ADD;
    end
    if (b.last) begin
      h0 = finish_lane(lane_q[0], b.len, 0);
      h1 = finish_lane(lane_q[1], b.len, 1);
      wd = '{h0[31:0], h0[63:32], h1[31:0], h1[63:32], 32'h0};
      r = '0;
      for (int j = 0; j < 4; j++) begin
        r = r | ({32'h0, wd[j+1]} << 32);
        r = r ^ {{32{wd[j][31]}}, wd[j]};
      end
      hash_expected_q.push_back(r);
      reload_lanes();
    end
  endfunction

  function automatic block_t make_block(input logic [63:0] w0, input logic [63:0] w1,
                                        input logic [63:0] w2, input logic [63:0] w3,
                                        input logic last, input logic [31:0] len);
    block_t b;
    b.words = {w3, w2, w1, w0};
    b.last  = last;
    b.len   = len;
    return b;
  endfunction

  function automatic logic [63:0] rand_word();
    int unsigned bit_pos;
    bit_pos = $urandom_range(0, 63);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return 64'h1 << bit_pos;
      3: return ~(64'h1 << bit_pos);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_msg_blocks();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 1;
    if (r < 7) return 2;
    if (r < 9) return $urandom_range(3, 6);
    return $urandom_range(7, 12);
  endfunction

  function automatic void push_message(input int nblk, input bit terminate);
    block_t      b;
    int unsigned valid_bytes;
    for (int n = 0; n < nblk; n++) begin
      for (int i = 0; i < 4; i++) b.words[i] = rand_word();
      b.last = terminate && (n == nblk - 1);
      b.len  = $urandom;
      if (b.last) begin
        case ($urandom_range(0, 5))
          0: b.len = '0;
          1: b.len = '1;
          2, 3: b.len = $urandom;
          default: begin
            valid_bytes = $urandom_range(1, 32);
            b.len = (nblk - 1) * 32 + valid_bytes;
            for (int j = valid_bytes; j < 32; j++) b.words[j/8][(j%8)*8 +: 8] = 8'h00;
          end
        endcase
      end
      pending_blocks.push_back(b);
    end
  endfunction

  function automatic int pick_gap();
    int unsigned r;
    if (calm_phase) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 96) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic int pick_stall();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return 0;
    if (r < 92) return $urandom_range(1, 4);
    if (r < 98) return $urandom_range(5, 25);
    return $urandom_range(40, 150);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch: %s", msg);
    err_cnt++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    while (pending_blocks.size() != 0 || in_ch.valid || hash_expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_seed(input logic [63:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    seed_q = v;
    reload_lanes();
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    @(negedge clk);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) absorb_block(cur_block);
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_ch.valid <= 1'b0;
        end else if (pending_blocks.size() != 0) begin
          cur_block = pending_blocks.pop_front();
          in_ch.block_word0    <= cur_block.words[0];
          in_ch.block_word1    <= cur_block.words[1];
          in_ch.block_word2    <= cur_block.words[2];
          in_ch.block_word3    <= cur_block.words[3];
          in_ch.last_block     <= cur_block.last;
          in_ch.message_length <= cur_block.len;
          in_ch.valid          <= 1'b1;
          gap_left = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
      hold_left  = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (hash_expected_q.size() == 0) begin
          report_mismatch($sformatf("hash %h with no message pending", out_ch.hash_value));
        end else if (out_ch.hash_value !== hash_expected_q[0]) begin
          report_mismatch($sformatf("hash %h, expected %h", out_ch.hash_value,
                                    hash_expected_q[0]));
          void'(hash_expected_q.pop_front());
        end else begin
          void'(hash_expected_q.pop_front());
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        if (!calm_phase) stall_left = pick_stall();
      end
    end
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin
    logic [63:0] extreme_seeds [4];
    int          made;
    int          phase;
    int          phase_items;
    int          nblk;
    clk                  = 1'b0;
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = '0;
    in_ch.valid          = 1'b0;
    in_ch.block_word0    = '0;
    in_ch.block_word1    = '0;
    in_ch.block_word2    = '0;
    in_ch.block_word3    = '0;
    in_ch.last_block     = 1'b0;
    in_ch.message_length = '0;
    out_ch.ready         = 1'b0;
    err_cnt              = 0;
    calm_phase           = 1'b0;
    hold_req             = 1'b0;
    seed_q               = '0;
    reload_lanes();
    extreme_seeds = '{64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h8000_0000_0000_0000,
                      64'h7FFF_FFFF_FFFF_FFFF};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // reset seed: empty message, all ones, a multi-block message
    pending_blocks.push_back(make_block('0, '0, '0, '0, 1'b1, '0));
    pending_blocks.push_back(make_block('1, '1, '1, '1, 1'b1, '1));
    pending_blocks.push_back(make_block(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
                                        64'h0123_4567_89AB_CDEF, 64'hFEDC_BA98_7654_3210,
                                        1'b0, 32'hFFFF_FFFF));
    pending_blocks.push_back(make_block(64'h8000_0000_8000_0000, 64'h7FFF_FFFF_7FFF_FFFF,
                                        64'h1, 64'h8000_0000_0000_0000, 1'b0, 32'h0));
    pending_blocks.push_back(make_block(64'h0000_0000_0061_6263, '0, '0, '0, 1'b1, 32'd67));
    pending_blocks.push_back(make_block(64'hFFFF_FFFF_0000_0000, 64'h0000_0000_FFFF_FFFF,
                                        '1, '0, 1'b1, 32'h8000_0000));
    wait_drained();
    write_seed(64'hFFFF_FFFF_FFFF_FFFF);
    pending_blocks.push_back(make_block('0, '0, '0, '0, 1'b1, '0));
    pending_blocks.push_back(make_block('1, '1, '1, '1, 1'b1, '0));
    wait_drained();
    write_seed(64'h8000_0000_0000_0000);
    pending_blocks.push_back(make_block('1, '0, '1, '0, 1'b0, '1));
    pending_blocks.push_back(make_block('0, '1, '0, '1, 1'b0, '0));
    wait_drained();
    // seed write drops the message in progress
    write_seed(64'h0123_4567_89AB_CDEF);
    pending_blocks.push_back(make_block(64'h1, 64'h2, 64'h3, 64'h4, 1'b1, 32'd32));

    made  = 0;
    phase = 0;
    while (made < RANDOM_ITEMS) begin
      wait_drained();
      write_seed(phase < 4 ? extreme_seeds[phase] : {$urandom, $urandom});
      calm_phase  = (phase == 3);
      phase_items = 0;
      if (phase == 1) begin
        hold_req = 1'b1;
        for (int i = 0; i < 12; i++) push_message(1, 1'b1);
        phase_items = 12;
      end
      while (phase_items < PHASE_ITEMS) begin
        nblk = pick_msg_blocks();
        push_message(nblk, 1'b1);
        phase_items += nblk;
      end
      if (phase == 2) begin
        push_message($urandom_range(1, 4), 1'b0);
        wait_drained();
        write_seed({$urandom, $urandom});
        push_message(2, 1'b1);
      end
      made += phase_items;
      phase++;
    end

    wait_drained();
    if (err_cnt == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule
